FILE: hdl/bms_pkg.sv
package bms_pkg;

    // default geometry
    localparam int unsigned DEF_BUCKET_COUNT     = 8;
    localparam int unsigned DEF_SLOTS_PER_BUCKET = 8;

    // item fields
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned FUNC_W  = 2;

    // remainder unit: reciprocal multiply, then multiply back and subtract
    localparam int unsigned MOD_STEPS = 2;
    localparam int unsigned MSTEP_W   = $clog2(MOD_STEPS + 1);

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_BASE,
        S_SCAN,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load;
        logic mod_step;
        logic base_calc;
        logic scan_step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

FILE: hdl/bms_mod_unit.sv
module bms_mod_unit
    import bms_pkg::*;
#(
    parameter int unsigned BUCKET_COUNT = DEF_BUCKET_COUNT,
    parameter int unsigned BW           = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_step,
    input  logic [VALUE_W-1:0] i_value,
    output logic [BW-1:0]      o_bucket,
    output logic               o_done
);

    // quotient by reciprocal: (v * RECIP) >> SHIFT is exact over the whole value range
    localparam int unsigned LOG_B = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 0;
    localparam int unsigned SHIFT = VALUE_W + LOG_B;
    localparam int unsigned RW    = VALUE_W + 1;
    localparam int unsigned PW    = VALUE_W + RW;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT);
    localparam logic [RW-1:0]      RECIP   = RW'(RECIP_FULL);
    localparam logic [VALUE_W-1:0] DIVISOR = VALUE_W'(BUCKET_COUNT);

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] r_quot;
    logic [BW-1:0]      r_rem;
    logic [MSTEP_W-1:0] r_cnt;
    logic [PW-1:0]      w_prod;
    logic [VALUE_W-1:0] w_quot;
    logic [VALUE_W-1:0] w_back;
    logic [VALUE_W-1:0] w_rem;

    // first step: quotient, second step: remainder
    assign w_prod = {{RW{1'b0}}, r_value} * {{VALUE_W{1'b0}}, RECIP};
    assign w_quot = VALUE_W'(w_prod >> SHIFT);
    assign w_back = r_quot * DIVISOR;
    assign w_rem  = r_value - w_back;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= i_value;
        end else if (i_step && (r_cnt == MSTEP_W'(0))) begin
            r_quot <= w_quot;
        end else if (i_step) begin
            r_rem <= w_rem[BW-1:0];
        end
    end

    assign o_bucket = r_rem;
    assign o_done   = (r_cnt == MSTEP_W'(MOD_STEPS));

endmodule

FILE: hdl/bms_datapath.sv
module bms_datapath
    import bms_pkg::*;
#(
    parameter int unsigned BUCKET_COUNT     = DEF_BUCKET_COUNT,
    parameter int unsigned SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic               o_bucket_full
);

    localparam int unsigned TOTAL = BUCKET_COUNT * SLOTS_PER_BUCKET;
    localparam int unsigned AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int unsigned BW    = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int unsigned SCW   = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int unsigned PW    = BW + SCW;
    localparam int unsigned EW    = VALUE_W + 1;

    // entry: valid bit on top of the stored value
    logic [EW-1:0] mem [TOTAL];

    logic [FUNC_W-1:0]  r_func;
    logic [VALUE_W-1:0] r_value;
    logic [BW-1:0]      w_bucket;
    logic               w_mod_done;
    logic [PW-1:0]      w_prod;
    logic [AW-1:0]      r_base;
    logic [SCW-1:0]     r_slot;
    logic [AW-1:0]      r_clr_addr;
    logic               w_rd_en;
    logic [AW-1:0]      w_raddr;
    logic [EW-1:0]      r_rd_data;
    logic [AW-1:0]      r_rd_addr_q;
    logic               r_pend;
    logic               w_hit;
    logic               r_present;
    logic               r_have_free;
    logic [AW-1:0]      r_free_addr;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [EW-1:0]      w_wdata;
    logic               r_out_valid;
    logic               r_found;
    logic               r_full;
    logic               w_out_free;

    // bucket = value mod bucket count
    bms_mod_unit #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .BW           (BW)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (i_cmd.load),
        .i_step   (i_cmd.mod_step),
        .i_value  (i_value),
        .o_bucket (w_bucket),
        .o_done   (w_mod_done)
    );

    // captured item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
    end

    // first slot of the bucket
    assign w_prod = {{SCW{1'b0}}, w_bucket} * {{BW{1'b0}}, SCW'(SLOTS_PER_BUCKET)};

    always_ff @(posedge i_clk) begin
        if (i_cmd.base_calc) begin
            r_base <= w_prod[AW-1:0];
        end
    end

    // slot counter for the bucket walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_cmd.base_calc) begin
            r_slot <= '0;
        end else if (w_rd_en) begin
            r_slot <= r_slot + 1'b1;
        end
    end

    assign w_rd_en = i_cmd.scan_step && (r_slot != SCW'(SLOTS_PER_BUCKET));
    assign w_raddr = r_base + AW'(r_slot);

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // read pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= w_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data   <= mem[w_raddr];
            r_rd_addr_q <= w_raddr;
        end
    end

    assign w_hit = r_pend && r_rd_data[EW-1] && (r_rd_data[VALUE_W-1:0] == r_value);

    // presence and first free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= 1'b0;
            r_have_free <= 1'b0;
        end else if (i_cmd.load) begin
            r_present   <= 1'b0;
            r_have_free <= 1'b0;
        end else if (r_pend) begin
            if (w_hit) begin
                r_present <= 1'b1;
            end
            if (!r_rd_data[EW-1] && !r_have_free) begin
                r_have_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && !r_rd_data[EW-1] && !r_have_free) begin
            r_free_addr <= r_rd_addr_q;
        end
    end

    // write port: clearing pass, remove of a match, or add
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wdata = '0;
        if (i_cmd.clear_step) begin
            w_we = 1'b1;
        end else if (w_hit && (r_func == FUNC_REMOVE)) begin
            w_we    = 1'b1;
            w_waddr = r_rd_addr_q;
        end else if (i_cmd.finish && (r_func == FUNC_ADD) && r_have_free) begin
            w_we    = 1'b1;
            w_waddr = r_free_addr;
            w_wdata = {1'b1, r_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    // result register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_found <= r_present && ((r_func == FUNC_ADD) || (r_func == FUNC_QUERY)
                                     || (r_func == FUNC_REMOVE));
            r_full  <= (r_func == FUNC_ADD) && !r_have_free;
        end
    end

    // status
    assign o_sts.clr_last  = (r_clr_addr == AW'(TOTAL - 1));
    assign o_sts.mod_done  = w_mod_done;
    assign o_sts.scan_done = (r_slot == SCW'(SLOTS_PER_BUCKET)) && !r_pend;
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_bucket_full = r_full;

    // a write-back never lands on the slot being read
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_rd_en) |-> (w_waddr != w_raddr))
        else $error("memory write and read at the same slot");

    // the walk never leaves its bucket
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SCW'(SLOTS_PER_BUCKET))
        else $error("slot counter past bucket end");

    // a result is only produced when the previous one has gone
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> w_out_free)
        else $error("result overwritten before it was taken");

    // bucket_full only ever comes from an add
    a_full_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (!r_full || (r_func == FUNC_ADD)))
        else $error("bucket_full on an operation other than add");

endmodule

FILE: hdl/bms_ctrl.sv
module bms_ctrl
    import bms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    n_state = S_BASE;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_BASE: begin
                o_cmd.base_calc = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/bucketed_membership_set.sv
// Set of 16-bit descriptor numbers held in BUCKET_COUNT buckets of SLOTS_PER_BUCKET
// slots; a value lives in bucket (value mod BUCKET_COUNT). func 0 adds the value in
// the lowest free slot of its bucket (duplicates allowed; a full bucket drops the add
// and sets bucket_full), func 1 queries, func 2 removes every copy; found tells whether
// the value was present before the operation, and func 3 changes nothing and returns
// zeros. One item is in work at a time; from acceptance to its result it passes through
// the remainder unit (reciprocal multiply, multiply back, hand-off), the forming of the
// bucket base, one read of the slot memory per slot of the bucket through its single
// read port, the drain of the last read that ends the walk, and the load of the output
// register. The input is ready again in the cycle after that. A new item is taken while
// the previous result still waits in the output register; a result that is not taken
// holds the next one in its last cycle. After reset the block runs a clearing pass over
// every slot before it takes the first item.
module bucketed_membership_set
    import bms_pkg::*;
#(
    parameter int unsigned BUCKET_COUNT     = DEF_BUCKET_COUNT,
    parameter int unsigned SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic               o_bucket_full
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    bms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // slot memory, remainder unit and result register
    bms_datapath #(
        .BUCKET_COUNT     (BUCKET_COUNT),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_func        (i_func),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_bucket_full (o_bucket_full)
    );

endmodule

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bms_pkg::*;

    localparam int unsigned TOTAL_SLOTS = DEF_BUCKET_COUNT * DEF_SLOTS_PER_BUCKET;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned POOL_SIZE = 32;

    typedef struct packed {
        logic found;
        logic bucket_full;
    } t_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [FUNC_W-1:0]  i_func = '0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_found;
    logic               o_bucket_full;

    // mirror of the slot memory
    logic [VALUE_W-1:0] mirror_value [TOTAL_SLOTS];
    logic               mirror_used [TOTAL_SLOTS];
    t_answer            answers_q [$];
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    int unsigned fail_count = 0;
    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned hits_seen = 0;
    int unsigned adds_dropped = 0;
    int unsigned cycle_count = 0;
    int unsigned ready_hold = 0;
    bit          gaps_on = 1'b1;

    bucketed_membership_set dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_bucket_full (o_bucket_full)
    );

    always #5 i_clk = ~i_clk;

    // predict one set operation and update the mirror
    task automatic apply_set_op(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] val,
                                output t_answer ans);
        int unsigned base;
        int          free_idx;
        logic        present;
        base = (val % DEF_BUCKET_COUNT) * DEF_SLOTS_PER_BUCKET;
        present = 1'b0;
        free_idx = -1;
        for (int i = 0; i < DEF_SLOTS_PER_BUCKET; i++) begin
            if (mirror_used[base + i]) begin
                if (mirror_value[base + i] == val) present = 1'b1;
            end else if (free_idx < 0) begin
                free_idx = base + i;
            end
        end
        ans = '0;
        case (op)
            FUNC_ADD: begin
                ans.found = present;
                if (free_idx >= 0) begin
                    mirror_value[free_idx] = val;
                    mirror_used[free_idx] = 1'b1;
                end else begin
                    ans.bucket_full = 1'b1;
                end
            end
            FUNC_QUERY: ans.found = present;
            FUNC_REMOVE: begin
                ans.found = present;
                for (int i = 0; i < DEF_SLOTS_PER_BUCKET; i++) begin
                    if (mirror_used[base + i] && mirror_value[base + i] == val)
                        mirror_used[base + i] = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    // send one item, called at a falling edge, returns at a falling edge
    task automatic send_item(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] val);
        t_answer     ans;
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_func = op;
        i_value = val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        apply_set_op(op, val, ans);
        answers_q.push_back(ans);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [FUNC_W-1:0] pick_op(input int unsigned add_weight);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < add_weight) return FUNC_ADD;
        if (r < add_weight + (95 - add_weight) / 2) return FUNC_QUERY;
        if (r < 95) return FUNC_REMOVE;
        return FUNC_UNUSED;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(input int unsigned pool_used);
        if ($urandom_range(0, 9) == 0) return VALUE_W'($urandom);
        return value_pool[$urandom_range(0, pool_used - 1)];
    endfunction

    task automatic test_basic_ops();
        send_item(FUNC_ADD, 16'd0);
        send_item(FUNC_QUERY, 16'd0);
        // duplicate add lands in a second slot
        send_item(FUNC_ADD, 16'd0);
        send_item(FUNC_QUERY, 16'd8);
        send_item(FUNC_REMOVE, 16'd8);
        send_item(FUNC_REMOVE, 16'd0);
        send_item(FUNC_QUERY, 16'd0);
        send_item(FUNC_ADD, 16'hFFFF);
        send_item(FUNC_QUERY, 16'hFFFF);
        send_item(FUNC_REMOVE, 16'hFFFF);
    endtask

    task automatic test_full_bucket();
        // fill bucket 3, one value twice
        send_item(FUNC_ADD, 16'd3);
        send_item(FUNC_ADD, 16'd11);
        send_item(FUNC_ADD, 16'd27);
        send_item(FUNC_ADD, 16'd35);
        send_item(FUNC_ADD, 16'd11);
        send_item(FUNC_ADD, 16'd43);
        send_item(FUNC_ADD, 16'd51);
        send_item(FUNC_ADD, 16'd65531);
        // dropped adds, present and absent
        send_item(FUNC_ADD, 16'd3);
        send_item(FUNC_ADD, 16'd19);
        // remove clears both copies, then room again
        send_item(FUNC_REMOVE, 16'd11);
        send_item(FUNC_ADD, 16'd19);
        send_item(FUNC_QUERY, 16'd11);
    endtask

    task automatic test_unused_code();
        send_item(FUNC_UNUSED, 16'd3);
        send_item(FUNC_UNUSED, 16'hFFFF);
    endtask

    // spread traffic over a pool of values across all buckets
    task automatic test_random_mix(input int unsigned n_items);
        for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = VALUE_W'($urandom);
        for (int i = 0; i < n_items; i++) begin
            send_item(pick_op(40), pick_value(POOL_SIZE));
        end
    endtask

    // few values sharing one bucket, so it fills and drains often
    task automatic test_bucket_pressure(input int unsigned n_items);
        int unsigned bucket;
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                bucket = $urandom_range(0, DEF_BUCKET_COUNT - 1);
                for (int k = 0; k < 6; k++)
                    value_pool[k] = VALUE_W'(($urandom_range(0, 8191) << 3) | bucket);
            end
            send_item(pick_op(55), pick_value(6));
        end
    endtask

    // back to back items, output ready apart from a stall burst still under way
    task automatic test_steady_stream(input int unsigned n_items);
        gaps_on = 1'b0;
        test_random_mix(n_items);
    endtask

    task automatic wait_for_answers();
        while (answers_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // output stall bursts
    always @(negedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold--;
            i_out_ready = 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            ready_hold = $urandom_range(1, 10) - 1;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_answer exp_ans;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answers_q.size() == 0) begin
                $display("%0t: unexpected result found=%0b bucket_full=%0b",
                         $time, o_found, o_bucket_full);
                fail_count++;
            end else begin
                exp_ans = answers_q.pop_front();
                results_checked++;
                if (o_found) hits_seen++;
                if (o_bucket_full) adds_dropped++;
                if (o_found !== exp_ans.found) begin
                    $display("%0t: found mismatch: expected %0b actual %0b",
                             $time, exp_ans.found, o_found);
                    fail_count++;
                end
                if (o_bucket_full !== exp_ans.bucket_full) begin
                    $display("%0t: bucket_full mismatch: expected %0b actual %0b",
                             $time, exp_ans.bucket_full, o_bucket_full);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run limit reached, %0d results still pending",
                     $time, answers_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TOTAL_SLOTS; i++) begin
            mirror_value[i] = '0;
            mirror_used[i] = 1'b0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_ops();
        test_full_bucket();
        test_unused_code();
        test_random_mix(1000);
        test_bucket_pressure(500);
        test_steady_stream(300);
        i_in_valid = 1'b0;
        wait_for_answers();

        $display("sent %0d items, checked %0d results in %0d cycles",
                 items_sent, results_checked, cycle_count);
        $display("membership hits %0d, dropped adds on full buckets %0d, errors %0d",
                 hits_seen, adds_dropped, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
